// ===== rtl/lome_pkg.sv =====
// ----------------------------------------------------------------------------
// lome_pkg
// Types and constants shared by the order matching engine.
// ----------------------------------------------------------------------------
package lome_pkg;

   localparam int NUM_ITEMS    = 10;
   localparam int BOOK_DEPTH   = 16;
   localparam int PRICE_WIDTH  = 16;
   localparam int QTY_WIDTH    = 16;
   localparam int TRADER_WIDTH = 8;

   localparam int ITEM_WIDTH   = 4;
   localparam int KIND_WIDTH   = 2;
   localparam int NUM_BOOKS    = 2 * NUM_ITEMS;
   localparam int BOOK_BITS    = $clog2(NUM_BOOKS);
   localparam int COUNT_BITS   = $clog2(BOOK_DEPTH + 1);
   localparam int MEM_DEPTH    = NUM_BOOKS * BOOK_DEPTH;
   localparam int ADDR_BITS    = $clog2(MEM_DEPTH);

   typedef logic [KIND_WIDTH-1:0] kind_type;
   localparam kind_type KIND_FILL = 2'd0;
   localparam kind_type KIND_DONE = 2'd1;
   localparam kind_type KIND_REJECT = 2'd2;

   typedef struct packed {
      logic                    side;
      logic [ITEM_WIDTH-1:0]   symbol;
      logic [PRICE_WIDTH-1:0]  limit_price;
      logic [QTY_WIDTH-1:0]    order_qty;
      logic [TRADER_WIDTH-1:0] account;
   } req_type;

   typedef struct packed {
      kind_type                result_kind;
      logic [TRADER_WIDTH-1:0] buyer_id;
      logic [TRADER_WIDTH-1:0] seller_id;
      logic [ITEM_WIDTH-1:0]   trade_item;
      logic [PRICE_WIDTH-1:0]  trade_price;
      logic [QTY_WIDTH-1:0]    trade_qty;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [PRICE_WIDTH-1:0]  price;
      logic [QTY_WIDTH-1:0]    qty;
      logic [TRADER_WIDTH-1:0] trader;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MRD,
      ST_MWAIT,
      ST_MCHK,
      ST_MOUT,
      ST_CRD,
      ST_CWAIT,
      ST_CWR,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WAIT,
      ST_SHIFT_WR,
      ST_INS,
      ST_FINAL
   } state_type;

endpackage

// ===== rtl/lome_if.sv =====
// ----------------------------------------------------------------------------
// lome_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface lome_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lome_book_ram.sv =====
// ----------------------------------------------------------------------------
// lome_book_ram
// Order book storage, one port, registered read.
// ----------------------------------------------------------------------------
module lome_book_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lome_pkg::ADDR_BITS-1:0] addr,
   input  lome_pkg::entry_type        wr_data,
   output lome_pkg::entry_type        rd_data
);
   import lome_pkg::*;

   entry_type mem_ff [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== rtl/lome_ctrl.sv =====
// ----------------------------------------------------------------------------
// lome_ctrl
// Sequencer: matching walk, compaction, insertion scan and shift.
// ----------------------------------------------------------------------------
module lome_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lome_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lome_pkg::rsp_type              rsp_data,
   output logic                           ram_wr,
   output logic [lome_pkg::ADDR_BITS-1:0] ram_addr,
   output lome_pkg::entry_type            ram_wdata,
   input  lome_pkg::entry_type            ram_rdata
);
   import lome_pkg::*;

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff [NUM_BOOKS];
   req_type   ord_ff;
   logic [QTY_WIDTH-1:0] qty_ff, qty_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;     // walk / scan / shift index
   logic [COUNT_BITS-1:0] rem_ff, rem_in;     // removed entries
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;     // working count
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic      rej_ff, rej_in;                 // final beat reports a reject
   entry_type ent_ff, ent_in;
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;

   logic [BOOK_BITS-1:0] own_book, opp_book;
   logic item_bad;
   logic [QTY_WIDTH-1:0] fill;
   logic crosses, ahead;
   logic out_free;

   assign item_bad = ord_ff.symbol >= ITEM_WIDTH'(NUM_ITEMS);
   assign own_book = BOOK_BITS'(ord_ff.side ? NUM_ITEMS : 0)
                     + BOOK_BITS'(ord_ff.symbol);
   assign opp_book = BOOK_BITS'(ord_ff.side ? 0 : NUM_ITEMS)
                     + BOOK_BITS'(ord_ff.symbol);
   // resting entry is held in ent_ff while its fill beat waits
   assign fill  = (ent_ff.qty < qty_ff) ? ent_ff.qty : qty_ff;
   assign crosses = ord_ff.side ? (ram_rdata.price >= ord_ff.limit_price)
                                : (ram_rdata.price <= ord_ff.limit_price);
   assign ahead = ord_ff.side ? (ram_rdata.price > ord_ff.limit_price)
                              : (ram_rdata.price < ord_ff.limit_price);
   assign out_free = !out_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [BOOK_BITS-1:0] b,
                                                    input logic [COUNT_BITS-1:0] i);
      return ADDR_BITS'(b) * ADDR_BITS'(BOOK_DEPTH) + ADDR_BITS'(i);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) state_in = ST_MRD;
         ST_MRD: begin
            if (item_bad) state_in = ST_FINAL;
            else if (idx_ff >= count_ff[opp_book] || qty_ff == '0) state_in = ST_CRD;
            else state_in = ST_MWAIT;
         end
         ST_MWAIT: state_in = ST_MCHK;
         ST_MCHK:  state_in = crosses ? ST_MOUT : ST_CRD;
         ST_MOUT:  if (out_free) state_in = ST_MRD;
         ST_CRD: begin
            if (rem_ff == '0 || idx_ff >= cnt_ff) state_in = ST_SCAN_RD;
            else state_in = ST_CWAIT;
         end
         ST_CWAIT: state_in = ST_CWR;
         ST_CWR:   state_in = ST_CRD;
         ST_SCAN_RD: begin
            if (qty_ff == '0 || count_ff[own_book] >= COUNT_BITS'(BOOK_DEPTH))
               state_in = ST_FINAL;
            else if (idx_ff >= count_ff[own_book]) state_in = ST_SHIFT_RD;
            else state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK:  state_in = ahead ? ST_SHIFT_RD : ST_SCAN_RD;
         ST_SHIFT_RD:  state_in = (idx_ff > pos_ff) ? ST_SHIFT_WAIT : ST_INS;
         ST_SHIFT_WAIT: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR:  state_in = ST_SHIFT_RD;
         ST_INS:   state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      qty_in = qty_ff;
      idx_in = idx_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      rej_in = rej_ff;
      ent_in = ent_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      ram_wr = 1'b0;
      ram_addr = addr_of(opp_book, idx_ff);
      ram_wdata = ent_ff;
      unique case (state_ff)
         ST_IDLE: begin
            qty_in = req_data.order_qty;
            idx_in = '0;
            rem_in = '0;
            rej_in = 1'b0;
         end
         ST_MRD: begin
            cnt_in = count_ff[opp_book];
            if (item_bad) rej_in = 1'b1;
            if (!(idx_ff < count_ff[opp_book] && qty_ff != '0)) idx_in = rem_ff;
         end
         ST_MCHK: begin
            if (crosses) ent_in = ram_rdata;
            else idx_in = rem_ff;
         end
         ST_MOUT: begin
            ram_wr = 1'b1;
            ram_wdata.qty = ent_ff.qty - fill;
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.result_kind = KIND_FILL;
               out_in.buyer_id  = ord_ff.side ? ent_ff.trader : ord_ff.account;
               out_in.seller_id = ord_ff.side ? ord_ff.account : ent_ff.trader;
               out_in.trade_item = ord_ff.symbol;
               out_in.trade_price = ent_ff.price;
               out_in.trade_qty = fill;
               out_in.last = 1'b0;
               qty_in = qty_ff - fill;
               if (ent_ff.qty == fill) rem_in = rem_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CRD: begin
            if (rem_ff == '0 || idx_ff >= cnt_ff) idx_in = '0;
         end
         ST_CWR: begin
            ram_addr = addr_of(opp_book, idx_ff - rem_ff);
            ram_wdata = ram_rdata;
            ram_wr = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_SCAN_RD: begin
            ram_addr = addr_of(own_book, idx_ff);
            pos_in = idx_ff;
            if (qty_ff != '0 && count_ff[own_book] >= COUNT_BITS'(BOOK_DEPTH))
               rej_in = 1'b1;
         end
         ST_SCAN_WAIT: ram_addr = addr_of(own_book, idx_ff);
         ST_SCAN_CHK: begin
            ram_addr = addr_of(own_book, idx_ff);
            if (ahead) idx_in = count_ff[own_book];
            else idx_in = idx_ff + 1'b1;
         end
         ST_SHIFT_RD, ST_SHIFT_WAIT: ram_addr = addr_of(own_book, idx_ff - 1'b1);
         ST_SHIFT_WR: begin
            ram_addr = addr_of(own_book, idx_ff);
            ram_wdata = ram_rdata;
            ram_wr = 1'b1;
            idx_in = idx_ff - 1'b1;
         end
         ST_INS: begin
            ram_addr = addr_of(own_book, pos_ff);
            ram_wdata.price = ord_ff.limit_price;
            ram_wdata.qty = qty_ff;
            ram_wdata.trader = ord_ff.account;
            ram_wr = 1'b1;
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.result_kind = rej_ff ? KIND_REJECT : KIND_DONE;
               out_in.buyer_id = '0;
               out_in.seller_id = '0;
               out_in.trade_item = ord_ff.symbol;
               out_in.trade_price = '0;
               out_in.trade_qty = qty_ff;
               out_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BOOKS; b++) count_ff[b] <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_CRD && (rem_ff == '0 || idx_ff >= cnt_ff) && !item_bad)
            count_ff[opp_book] <= cnt_ff - rem_ff;
         if (state_ff == ST_INS)
            count_ff[own_book] <= count_ff[own_book] + 1'b1;
      end
      if (state_ff == ST_IDLE) ord_ff <= req_data;
      qty_ff <= qty_in;
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      rej_ff <= rej_in;
      ent_ff <= ent_in;
      out_ff <= out_in;
   end
endmodule

// ===== rtl/limit_order_matching_engine.sv =====
// ----------------------------------------------------------------------------
// limit_order_matching_engine
// Price-time priority order matching over per-item buy and sell books.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | side, symbol, limit_price, order_qty, account
//  rsp     | out | result_kind, buyer_id, seller_id, trade_item, trade_price,
//          |     | trade_qty, last
// One order walks opposite entries, compacts the opposite book, then scans
// and shifts own entries before inserting; each step goes through the
// single book RAM port with its registered read.
// Reset is synchronous and empties all books at once via the count registers.
// A stalled rsp holds the sequencer; req is taken only while idle.
module limit_order_matching_engine (
   input logic clock,
   input logic reset,
   lome_if.sink   req,
   lome_if.source rsp
);
   import lome_pkg::*;

   logic                 ram_wr;
   logic [ADDR_BITS-1:0] ram_addr;
   entry_type            ram_wdata, ram_rdata;

   lome_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready), .req_data (req.payload),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_data (rsp.payload),
      .ram_wr, .ram_addr, .ram_wdata, .ram_rdata
   );

   lome_book_ram u_ram (
      .clock, .wr_en (ram_wr), .addr (ram_addr), .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.result_kind == KIND_FILL |-> !rsp.payload.last)
      else $error("fill beat marked last");
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.result_kind != KIND_FILL |-> rsp.payload.last)
      else $error("final beat not marked last");
   a_fill_qty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.result_kind == KIND_FILL |-> rsp.payload.trade_qty != '0)
      else $error("empty fill");
endmodule
